// ===== src/sibt_pkg.sv =====
// shared types and constants of the initialized-byte tracker
package sibt_pkg;

    // bytes tracked by one bitmap word
    localparam int WORD_BITS     = 32;
    localparam int WORD_SEL_BITS = 5;

    typedef logic [WORD_BITS-1:0] t_word;

    // request action codes
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_MARK  = 2'd1;
    localparam logic [1:0] ACT_CHECK = 2'd2;

    // request transfer
    typedef struct packed {
        logic [1:0]  action;
        logic        space;
        logic [11:0] start_address;
        logic [12:0] byte_count;
    } t_req;

    // result transfer
    typedef struct packed {
        logic        uninit_found;
        logic [11:0] first_uninit_address;
        logic        range_invalid;
    } t_rsp;

endpackage

// ===== src/shadow_init_byte_tracker.sv =====
// Shadow initialized-byte tracker: one bit per byte for the global and local spaces,
// kept as 32-bit words in a single one-port-read, one-port-write memory. A request
// is accepted in the idle state, then each 32-byte word its range touches is read and
// then modified and written back or tested, then the result register is loaded once it
// is empty or being drained. A check stops at the first word that holds an
// uninitialized byte. Requests that are out of range, empty or carry the unused action
// code go straight to the result register. After reset the block clears the memory one
// word a cycle, both spaces, and takes no request until that pass is done. A new request
// is taken while the previous result still waits at the output.
module shadow_init_byte_tracker #(
    parameter int MEM_BYTES = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sibt_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sibt_pkg::t_rsp o_out_data
);
    import sibt_pkg::*;

    localparam int ADDR_BITS = $clog2(MEM_BYTES);
    localparam int WA        = ADDR_BITS - WORD_SEL_BITS;
    localparam int MA        = WA + 1;
    localparam int SUM_BITS  = (ADDR_BITS + 1 > 14) ? ADDR_BITS + 1 : 14;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MOD,
        ST_OUT
    } t_state;

    t_state                   r_state;
    logic [MA-1:0]            r_clr;
    logic [1:0]               r_act;
    logic                     r_space;
    logic [WA-1:0]            r_word;
    logic [WA-1:0]            r_last;
    logic [WORD_SEL_BITS-1:0] r_lo;
    logic [WORD_SEL_BITS-1:0] r_hi;
    logic                     r_found;
    logic [11:0]              r_addr;
    logic                     r_inv;
    logic                     r_out_valid;
    t_rsp                     r_out;

    logic                     in_xfer;
    logic                     out_load;
    logic [SUM_BITS-1:0]      start_w;
    logic [SUM_BITS-1:0]      end_w;
    logic [SUM_BITS-1:0]      endm1_w;
    logic                     out_of_range;

    logic                     ram_rd_en;
    logic                     ram_wr_en;
    logic [MA-1:0]            ram_rd_addr;
    logic [MA-1:0]            ram_wr_addr;
    t_word                    ram_wr_data;
    t_word                    ram_rd_data;

    logic [WORD_SEL_BITS-1:0] hi_eff;
    t_word                    mask;
    t_word                    uninit;
    t_word                    lowest;
    logic [WORD_SEL_BITS-1:0] lowest_idx;
    logic [ADDR_BITS-1:0]     hit_addr;

    // request decode
    assign in_xfer      = i_in_valid && (r_state == ST_IDLE);
    assign start_w      = SUM_BITS'(i_in_data.start_address);
    assign end_w        = start_w + SUM_BITS'(i_in_data.byte_count);
    assign endm1_w      = end_w - SUM_BITS'(1);
    assign out_of_range = end_w > SUM_BITS'(MEM_BYTES);

    // result register loads when it is empty or being drained
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    // byte mask of the current word
    assign hi_eff = (r_word == r_last) ? r_hi : {WORD_SEL_BITS{1'b1}};
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            mask[b] = (WORD_SEL_BITS'(b) >= r_lo) && (WORD_SEL_BITS'(b) <= hi_eff);
        end
    end

    // lowest uninitialized byte of the word
    assign uninit = ~ram_rd_data & mask;
    assign lowest = uninit & (~uninit + t_word'(1));
    always_comb begin
        lowest_idx = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            lowest_idx = lowest_idx | (lowest[j] ? WORD_SEL_BITS'(j) : '0);
        end
    end
    assign hit_addr = {r_word, lowest_idx};

    // memory control
    assign ram_rd_en   = (r_state == ST_READ);
    assign ram_rd_addr = {r_space, r_word};
    assign ram_wr_en   = (r_state == ST_CLEAR)
                         || ((r_state == ST_MOD) && (r_act != ACT_CHECK));
    assign ram_wr_addr = (r_state == ST_CLEAR) ? r_clr : {r_space, r_word};
    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_wr_data = '0;
        end else if (r_act == ACT_MARK) begin
            ram_wr_data = ram_rd_data | mask;
        end else begin
            ram_wr_data = ram_rd_data & ~mask;
        end
    end

    sibt_bitmap_ram #(
        .ADDR_W (MA)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data)
    );

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + MA'(1);
                    if (r_clr == {MA{1'b1}}) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_act   <= i_in_data.action;
                        r_space <= i_in_data.space;
                        r_word  <= start_w[ADDR_BITS-1:WORD_SEL_BITS];
                        r_last  <= endm1_w[ADDR_BITS-1:WORD_SEL_BITS];
                        r_lo    <= start_w[WORD_SEL_BITS-1:0];
                        r_hi    <= endm1_w[WORD_SEL_BITS-1:0];
                        r_found <= 1'b0;
                        r_addr  <= '0;
                        r_inv   <= 1'b0;
                        priority if (i_in_data.action != ACT_ALLOC
                                     && i_in_data.action != ACT_MARK
                                     && i_in_data.action != ACT_CHECK) begin
                            r_state <= ST_OUT;
                        end else if (out_of_range) begin
                            r_inv   <= 1'b1;
                            r_state <= ST_OUT;
                        end else if (i_in_data.byte_count == '0) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    r_state <= ST_MOD;
                end
                ST_MOD: begin
                    priority if (r_act == ACT_CHECK && uninit != '0) begin
                        r_found <= 1'b1;
                        r_addr  <= 12'(hit_addr);
                        r_state <= ST_OUT;
                    end else if (r_word == r_last) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_word  <= r_word + WA'(1);
                        r_lo    <= '0;
                        r_state <= ST_READ;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_out.uninit_found         <= r_found;
                        r_out.first_uninit_address <= r_addr;
                        r_out.range_invalid        <= r_inv;
                        r_state                    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/sibt_bitmap_ram.sv =====
// bitmap memory: one write port, one read port, registered read data
module sibt_bitmap_ram #(
    parameter int ADDR_W = 8
) (
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    output sibt_pkg::t_word    o_rd_data,
    input  logic               i_wr_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  sibt_pkg::t_word    i_wr_data
);
    import sibt_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    t_word r_mem [0:DEPTH-1];
    t_word r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== tb/tb_shadow_init_byte_tracker.sv =====
// testbench for the shadow initialized-byte tracker: directed table, then random range traffic
`timescale 1ns / 1ps

module tb_shadow_init_byte_tracker;
    import sibt_pkg::*;

    localparam int         MEM_BYTES   = 4096;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         TOTAL_ITEMS = 650;
    localparam int         CALM_ITEMS  = 60;
    localparam int         STALL_LIMIT = 3000;
    localparam int         MAX_PRINTS  = 64;

    // one row of the directed table
    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_dir_row;

    // expected result with the number of the request that caused it
    typedef struct {
        t_rsp rsp;
        int   tag;
    } t_pending;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_req in_data;
    logic out_valid;
    logic out_ready;
    t_rsp out_data;

    // shadow copy of the initialized bits, index 0 global, 1 local
    bit       init_bits [2][MEM_BYTES];
    t_pending pending_rsp [$];
    t_dir_row dir_rows [$];

    int  errors;
    int  items_sent;
    int  results_seen;
    int  invalid_cnt;
    int  uninit_hits;
    int  unused_cnt;
    bit  calm;

    shadow_init_byte_tracker #(
        .MEM_BYTES(MEM_BYTES)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic flag_error(string msg);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    // apply one request to the shadow bits and work out its result
    function automatic t_rsp track_request(t_req r);
        t_rsp rsp;
        int   sp;
        int   first;
        int   last;
        rsp   = '0;
        sp    = int'(r.space);
        first = int'(r.start_address);
        last  = first + int'(r.byte_count);
        if (r.action == ACT_UNUSED) begin
            return rsp;
        end
        if (last > MEM_BYTES) begin
            rsp.range_invalid = 1'b1;
            return rsp;
        end
        case (r.action)
            ACT_ALLOC: begin
                for (int i = first; i < last; i++) init_bits[sp][i] = 1'b0;
            end
            ACT_MARK: begin
                for (int i = first; i < last; i++) init_bits[sp][i] = 1'b1;
            end
            default: begin
                for (int i = first; i < last; i++) begin
                    if (!init_bits[sp][i]) begin
                        rsp.uninit_found         = 1'b1;
                        rsp.first_uninit_address = i[11:0];
                        break;
                    end
                end
            end
        endcase
        return rsp;
    endfunction

    function automatic t_req mk_req(logic [1:0] act, bit sp, int start, int count);
        t_req r;
        r.action        = act;
        r.space         = sp;
        r.start_address = start[11:0];
        r.byte_count    = count[12:0];
        return r;
    endfunction

    function automatic t_dir_row row(logic [1:0] act, bit sp, int start, int count,
                                     bit typed, bit found = 1'b0, int addr = 0,
                                     bit inv = 1'b0);
        t_dir_row d;
        d.req                      = mk_req(act, sp, start, count);
        d.typed                    = typed;
        d.rsp.uninit_found         = found;
        d.rsp.first_uninit_address = addr[11:0];
        d.rsp.range_invalid        = inv;
        return d;
    endfunction

    // drive one request from a falling edge until its transfer, then maybe idle
    task automatic send(t_req r, bit typed, t_rsp typed_rsp);
        t_rsp     pred;
        t_pending p;
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pred = track_request(r);
        p.rsp = typed ? typed_rsp : pred;
        p.tag = items_sent;
        pending_rsp.push_back(p);
        items_sent++;
        if (r.action == ACT_UNUSED) unused_cnt++;
        if (pred.range_invalid) invalid_cnt++;
        if (pred.uninit_found) uninit_hits++;
        calm = (items_sent >= TOTAL_ITEMS - CALM_ITEMS);
        @(negedge clk);
        if (!calm && $urandom_range(0, 99) < 20) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
    endtask

    task automatic send_pred(t_req r);
        send(r, 1'b0, '0);
    endtask

    // hold the sender off until every expected result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_rsp.size() > 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pick_sub(input int s, input int n, output int a, output int len);
        a   = s + int'($urandom_range(0, n - 1));
        len = int'($urandom_range(0, s + n - a));
    endtask

    // allocate a region, mark pieces of it, then probe it with checks
    task automatic run_sequence();
        int  s;
        int  n;
        int  a;
        int  len;
        bit  sp;
        sp = 1'($urandom_range(0, 1));
        s  = $urandom_range(0, MEM_BYTES - 1);
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, MEM_BYTES - s);
        end else begin
            n = $urandom_range(1, (MEM_BYTES - s < 96) ? MEM_BYTES - s : 96);
        end
        send_pred(mk_req(ACT_ALLOC, sp, s, n));
        repeat ($urandom_range(0, 3)) begin
            pick_sub(s, n, a, len);
            send_pred(mk_req(ACT_MARK, sp, a, len));
        end
        if ($urandom_range(0, 1)) begin
            send_pred(mk_req(ACT_CHECK, sp, s, n));
        end
        repeat ($urandom_range(1, 3)) begin
            pick_sub(s, n, a, len);
            send_pred(mk_req(ACT_CHECK, sp, a, len));
        end
    endtask

    // single request with arbitrary fields, boundary ranges among them
    task automatic run_noise();
        int start;
        int count;
        start = $urandom_range(0, MEM_BYTES - 1);
        case ($urandom_range(0, 3))
            0:       count = $urandom_range(0, 8191);
            1:       count = MEM_BYTES - start + int'($urandom_range(0, 3));
            2:       count = 0;
            default: count = $urandom_range(0, 64);
        endcase
        send_pred(mk_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), start, count));
    endtask

    // result side: random stall bursts, none near the end
    initial begin : ready_gen
        int gap;
        gap       = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (calm) begin
                out_ready <= 1'b1;
            end else if (gap > 0) begin
                out_ready <= 1'b0;
                gap--;
            end else if ($urandom_range(0, 99) < 15) begin
                gap = $urandom_range(1, 9) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk) begin
        t_pending p;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (pending_rsp.size() == 0) begin
                flag_error($sformatf("result with nothing expected: %p", out_data));
            end else begin
                p = pending_rsp.pop_front();
                if (out_data.uninit_found !== p.rsp.uninit_found
                    || out_data.first_uninit_address !== p.rsp.first_uninit_address
                    || out_data.range_invalid !== p.rsp.range_invalid) begin
                    flag_error($sformatf({"request %0d: got found=%0b addr=%0d inv=%0b, ",
                                          "exp found=%0b addr=%0d inv=%0b"},
                               p.tag, out_data.uninit_found, out_data.first_uninit_address,
                               out_data.range_invalid, p.rsp.uninit_found,
                               p.rsp.first_uninit_address, p.rsp.range_invalid));
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
        end
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_rsp.size());
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus
    initial begin
        errors       = 0;
        items_sent   = 0;
        results_seen = 0;
        invalid_cnt  = 0;
        uninit_hits  = 0;
        unused_cnt   = 0;
        calm         = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;

        // directed table: reset state, whole-store extremes, errors, empty ranges
        dir_rows = '{
            row(ACT_CHECK,  0, 0,    4096, 1, 1, 0),
            row(ACT_CHECK,  1, 4095, 1,    1, 1, 4095),
            row(ACT_MARK,   0, 0,    4096, 1),
            row(ACT_CHECK,  0, 0,    4096, 1),
            row(ACT_ALLOC,  0, 4095, 1,    1),
            row(ACT_CHECK,  0, 4064, 32,   1, 1, 4095),
            row(ACT_ALLOC,  0, 100,  5,    0),
            row(ACT_CHECK,  0, 0,    4096, 0),
            row(ACT_MARK,   0, 100,  5,    0),
            row(ACT_CHECK,  0, 96,   8,    0),
            row(ACT_CHECK,  0, 4095, 2,    1, 0, 0, 1),
            row(ACT_MARK,   1, 1,    4096, 1, 0, 0, 1),
            row(ACT_CHECK,  0, 4095, 8191, 1, 0, 0, 1),
            row(ACT_ALLOC,  1, 0,    8191, 1, 0, 0, 1),
            row(ACT_UNUSED, 1, 4095, 8191, 1),
            row(ACT_UNUSED, 0, 0,    0,    1),
            row(ACT_CHECK,  0, 0,    0,    1),
            row(ACT_ALLOC,  0, 4095, 0,    1),
            row(ACT_CHECK,  0, 4095, 0,    1),
            row(ACT_MARK,   1, 30,   5,    0),
            row(ACT_CHECK,  1, 28,   10,   0),
            row(ACT_CHECK,  1, 30,   5,    0),
            row(ACT_MARK,   1, 4064, 32,   0),
            row(ACT_CHECK,  1, 4060, 36,   0),
            row(ACT_CHECK,  0, 0,    4096, 0),
            row(ACT_ALLOC,  0, 0,    4096, 1)
        };

        // reset, released on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i]) begin
            send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
        end
        drain();

        // random traffic, mostly alloc-mark-check sequences, with full pauses around the midpoint
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= TOTAL_ITEMS / 2 && items_sent < TOTAL_ITEMS / 2 + 8) begin
                drain();
            end
            if ($urandom_range(0, 9) < 7) run_sequence();
            else run_noise();
        end

        drain();
        repeat (20) @(posedge clk);

        $display("covered %0d requests and %0d results: %0d out-of-range, %0d unused action",
                 items_sent, results_seen, invalid_cnt, unused_cnt);
        $display("checks that hit an uninitialized byte: %0d, mismatches: %0d",
                 uninit_hits, errors);
        if (errors == 0 && pending_rsp.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
